// ===== rtl/wq_pkg.sv =====
// shared types, codes and constants of the weight quantizer
package wq_pkg;

   localparam logic [1:0] MODE_FP32 = 2'd0;
   localparam logic [1:0] MODE_BF16 = 2'd1;
   localparam logic [1:0] MODE_INT8 = 2'd2;

   localparam logic [1:0] KIND_SCALE = 2'd0;
   localparam logic [1:0] KIND_FP32  = 2'd1;
   localparam logic [1:0] KIND_BF16  = 2'd2;
   localparam logic [1:0] KIND_CODE  = 2'd3;

   localparam logic [31:0] FP32_ONE    = 32'h3F80_0000;
   localparam logic [31:0] FP32_127    = 32'h42FE_0000;
   localparam logic [30:0] FP32_INF    = 31'h7F80_0000;
   localparam logic [31:0] FP32_NAN    = 32'h7FC0_0000;
   localparam logic [6:0]  CODE_LIMIT  = 7'd127;

   localparam int unsigned DIV_STEPS = 25;

   typedef struct packed {
      logic        req_type;
      logic [31:0] element_bits;
      logic        tensor_last;
   } req_word_type;

   typedef struct packed {
      logic [1:0]        word_kind;
      logic [31:0]       out_word;
      logic signed [7:0] code_value;
   } rsp_word_type;

   typedef struct packed {
      logic accept;
      logic div_load;
      logic norm_step;
      logic align_step;
      logic div_step;
      logic round_step;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       special;
      logic       need_norm;
   } dp_status_type;

endpackage

// ===== rtl/wq_datapath.sv =====
// datapath: mode register, scan maximum, scale, fp32 divider and int8 rounding
module wq_datapath import wq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_wr_data,
   input  req_word_type  req_word,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output rsp_word_type  rsp_word
);

   logic [1:0]         mode_ff;
   logic [31:0]        max_ff, max_in;
   logic [31:0]        scale_ff, scale_in;
   logic [31:0]        elem_ff;
   logic               scan_ff;
   logic               sign_ff;
   logic signed [10:0] exp_ff, exp_in;
   logic [23:0]        ma_ff, ma_in, mb_ff, mb_in;
   logic [24:0]        rem_ff, rem_in;
   logic [24:0]        quo_ff, quo_in;
   logic               sp_ff, sp_in;
   logic [31:0]        res_ff, res_in;
   rsp_word_type       rsp_ff, rsp_in;

   logic [30:0] mag;
   logic [31:0] opa, opb;
   logic [7:0]  xa, xb;
   logic [22:0] fa, fb;
   logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sgn;
   logic [25:0] diff;
   logic        ge;
   logic        sticky, lost, g, lsb, inc;
   logic [10:0] shw;
   logic [4:0]  shv;
   logic [25:0] mask;
   logic [24:0] qs;
   logic [30:0] packed_res;
   logic [31:0] sc;
   logic [23:0] qm;
   logic [7:0]  h, hr;
   logic [4:0]  qsh;
   logic [6:0]  qmag;
   logic [7:0]  code;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_FP32;
         max_ff   <= '0;
         scale_ff <= FP32_ONE;
      end else begin
         if (csr_wr_en) mode_ff <= csr_wr_data;
         max_ff   <= max_in;
         scale_ff <= scale_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         elem_ff <= req_word.element_bits;
         scan_ff <= !req_word.req_type;
      end
      if (cmd.div_load) sign_ff <= sgn;
      exp_ff <= exp_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      sp_ff  <= sp_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign mag = req_word.element_bits[30:0];

   // scan maximum
   always_comb begin
      max_in = max_ff;
      if (cmd.accept && mode_ff == MODE_INT8 && !req_word.req_type &&
          mag <= FP32_INF && {1'b0, mag} > max_ff)
         max_in = {1'b0, mag};
      if (cmd.div_load && scan_ff) max_in = '0;
   end

   // operand unpack and special cases
   always_comb begin
      opa    = scan_ff ? max_ff : elem_ff;
      opb    = scan_ff ? FP32_127 : scale_ff;
      xa     = opa[30:23];
      xb     = opb[30:23];
      fa     = opa[22:0];
      fb     = opb[22:0];
      nan_a  = (xa == 8'hFF) && (fa != '0);
      nan_b  = (xb == 8'hFF) && (fb != '0);
      inf_a  = (xa == 8'hFF) && (fa == '0);
      inf_b  = (xb == 8'hFF) && (fb == '0);
      zero_a = (xa == 8'h00) && (fa == '0);
      zero_b = (xb == 8'h00) && (fb == '0);
      sgn    = opa[31] ^ opb[31];
   end

   // divider steps
   always_comb begin
      exp_in = exp_ff;
      ma_in  = ma_ff;
      mb_in  = mb_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      sp_in  = sp_ff;
      res_in = res_ff;
      diff   = {1'b0, rem_ff} - {2'b0, mb_ff};
      ge     = !diff[25];
      sticky = rem_ff != '0;
      shw    = 11'd1 - exp_ff;
      shv    = (shw > 11'd26) ? 5'd26 : shw[4:0];
      mask   = (26'd1 << shv) - 26'd1;
      lost   = |({1'b0, quo_ff} & mask);
      qs     = quo_ff >> shv;
      if (exp_ff >= 11'sd1) begin
         packed_res = {exp_ff[7:0], quo_ff[23:1]};
         g   = quo_ff[0];
         lsb = quo_ff[1];
         inc = g && (sticky || lsb);
      end else begin
         packed_res = {8'd0, qs[23:1]};
         g   = qs[0];
         lsb = qs[1];
         inc = g && (sticky || lost || lsb);
      end
      if (cmd.div_load) begin
         ma_in  = {xa != 8'h00, fa};
         mb_in  = {xb != 8'h00, fb};
         exp_in = 11'(signed'({3'b0, (xa == 8'h00) ? 8'd1 : xa}))
                - 11'(signed'({3'b0, (xb == 8'h00) ? 8'd1 : xb})) + 11'sd127;
         sp_in  = 1'b1;
         if (nan_a || nan_b || (inf_a && inf_b) || (zero_a && zero_b))
            res_in = FP32_NAN;
         else if (inf_a || zero_b)
            res_in = {sgn, FP32_INF};
         else if (zero_a || inf_b)
            res_in = {sgn, 31'd0};
         else
            sp_in = 1'b0;
      end
      if (cmd.norm_step) begin
         if (!ma_ff[23]) ma_in = {ma_ff[22:0], 1'b0};
         if (!mb_ff[23]) mb_in = {mb_ff[22:0], 1'b0};
         exp_in = exp_ff - 11'(signed'({10'd0, !ma_ff[23]}))
                         + 11'(signed'({10'd0, !mb_ff[23]}));
      end
      if (cmd.align_step) begin
         quo_in = '0;
         if (ma_ff < mb_ff) begin
            rem_in = {ma_ff, 1'b0};
            exp_in = exp_ff - 11'sd1;
         end else begin
            rem_in = {1'b0, ma_ff};
         end
      end
      if (cmd.div_step) begin
         rem_in = ge ? {diff[23:0], 1'b0} : {rem_ff[23:0], 1'b0};
         quo_in = {quo_ff[23:0], ge};
      end
      if (cmd.round_step) begin
         if (exp_ff >= 11'sd255) res_in = {sign_ff, FP32_INF};
         else res_in = {sign_ff, packed_res + {30'd0, inc}};
      end
   end

   // int8 code from the rounded quotient
   always_comb begin
      qm   = {1'b1, res_ff[22:0]};
      qsh  = 5'(8'd149 - res_ff[30:23]);
      h    = 8'(qm >> qsh);
      hr   = h + 8'd1;
      if (res_ff[30:0] > FP32_INF) qmag = '0;
      else if (res_ff[30:0] >= FP32_127[30:0]) qmag = CODE_LIMIT;
      else if (res_ff[30:23] < 8'd126) qmag = '0;
      else qmag = hr[7:1];
      code = res_ff[31] ? 8'(-{1'b0, qmag}) : {1'b0, qmag};
      sc   = (res_ff == '0) ? FP32_ONE : res_ff;
   end

   always_comb begin
      rsp_in   = rsp_ff;
      scale_in = scale_ff;
      if (cmd.out_load) begin
         rsp_in.code_value = '0;
         if (mode_ff == MODE_FP32) begin
            rsp_in.word_kind = KIND_FP32;
            rsp_in.out_word  = elem_ff;
         end else if (mode_ff == MODE_BF16) begin
            rsp_in.word_kind = KIND_BF16;
            rsp_in.out_word  = {16'd0, elem_ff[31:16]};
         end else if (scan_ff) begin
            rsp_in.word_kind = KIND_SCALE;
            rsp_in.out_word  = sc;
            scale_in         = sc;
         end else begin
            rsp_in.word_kind  = KIND_CODE;
            rsp_in.out_word   = {24'd0, code};
            rsp_in.code_value = signed'(code);
         end
      end
   end

   assign status.mode      = mode_ff;
   assign status.special   = sp_ff;
   assign status.need_norm = !ma_ff[23] || !mb_ff[23];
   assign rsp_word         = rsp_ff;

endmodule

// ===== rtl/wq_controller.sv =====
// controller: sequences accept, divide, round and result handoff
module wq_controller import wq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_word_type  req_word,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      IDLE, EMIT, LOAD, NORM, ALIGN, DIV, ROUND, FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       hold_ff, hold_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hold_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         hold_ff      <= hold_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      hold_in      = hold_ff;
      cmd          = '0;
      req_ready    = (state_ff == IDLE) && !hold_ff;
      if (hold_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
         hold_in      = 1'b0;
      end
      unique case (state_ff)
         IDLE: begin
            if (req_valid && req_ready) begin
               cmd.accept = 1'b1;
               if (status.mode == MODE_FP32 || status.mode == MODE_BF16)
                  state_in = EMIT;
               else if (status.mode == MODE_INT8 &&
                        (req_word.req_type || req_word.tensor_last))
                  state_in = LOAD;
            end
         end
         EMIT: begin
            cmd.out_load = 1'b1;
            rsp_valid_in = 1'b1;
            hold_in      = 1'b1;
            state_in     = IDLE;
         end
         LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = NORM;
         end
         NORM: begin
            if (status.special) state_in = FINISH;
            else if (status.need_norm) cmd.norm_step = 1'b1;
            else state_in = ALIGN;
         end
         ALIGN: begin
            cmd.align_step = 1'b1;
            cnt_in         = '0;
            state_in       = DIV;
         end
         DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) state_in = ROUND;
         end
         ROUND: begin
            cmd.round_step = 1'b1;
            state_in       = FINISH;
         end
         FINISH: begin
            cmd.out_load = 1'b1;
            rsp_valid_in = 1'b1;
            hold_in      = 1'b1;
            state_in     = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/weight_quantizer_int8_bf16.sv =====
// weight quantizer top level: fp32 copy, bf16 truncation or int8 quantization
//
// req channel: one fp32 weight word per handshake, with its pass type and
// tensor_last flag. rsp channel: one result word, a scale, a copy, a bf16 half
// or an int8 code. csr_wr_en/csr_wr_data write the mode; the user must write
// the mode only while idle, the block does not enforce it. Modes 0 and 1:
// the accepted word passes through EMIT to the output register. Mode 2 scan
// words that are not last give no result. A last scan word or a quantize word
// runs through a radix-2 fp32 divider with 25 quotient steps, in the states
// LOAD, NORM (one normalizing shift per step for a subnormal operand, up to
// 23 shifts), ALIGN, DIV, ROUND and FINISH; a special quotient skips from
// NORM to FINISH. One word is in flight at a time; the divider sets the rate.
// A new word is taken only after the previous result has been taken.
// If the receiver stalls, the result holds in the output register and req_ready
// stays low until rsp_ready rises.
// Reset sets mode 0, clears the running maximum and sets the scale to 1.0.
module weight_quantizer_int8_bf16 import wq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   wq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wq_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_word    (req_word),
      .cmd         (cmd),
      .status      (status),
      .rsp_word    (rsp_word)
   );

endmodule
